[hw/rtl/gap_tracking_table_with_ttl_assert.svh]
// assertion macros for the gap tracking table checker
`ifndef GAP_TRACKING_TABLE_WITH_TTL_ASSERT_SVH
`define GAP_TRACKING_TABLE_WITH_TTL_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GTTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GTTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/gttl_pkg.sv]
// shared types and constants of the gap tracking table
package gttl_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 256;
  localparam int WORD_W    = 64;
  localparam int TIME_BITS = 48;
  localparam int TTL_W     = 48;
  localparam int MODE_W    = 3;

  localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_TRACK    = 3'd0,
    MODE_RESOLVE  = 3'd1,
    MODE_ROLLBACK = 3'd2,
    MODE_EVICT    = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

[hw/rtl/gttl_ctrl.sv]
// controller state machine of the gap tracking table
module gttl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  gttl_pkg::dp_status_t   sts,
  output gttl_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // one transaction in flight at a time
  assign in_stall = (state != S_IDLE);

endmodule

[hw/rtl/gttl_datapath.sv]
// entry memories, valid bits, scan compare and result register
module gttl_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  gttl_pkg::ctrl_cmd_t                 cmd,
  output gttl_pkg::dp_status_t                sts,
  input  logic                                cfg_we,
  input  logic [gttl_pkg::TTL_W-1:0]          cfg_data,
  input  logic [gttl_pkg::MODE_W-1:0]         mode,
  input  logic [gttl_pkg::WORD_W-1:0]         key_word0,
  input  logic [gttl_pkg::WORD_W-1:0]         key_word1,
  input  logic [gttl_pkg::WORD_W-1:0]         key_word2,
  input  logic [gttl_pkg::WORD_W-1:0]         key_word3,
  input  logic [gttl_pkg::WORD_W-1:0]         owner_word0,
  input  logic [gttl_pkg::WORD_W-1:0]         owner_word1,
  input  logic [gttl_pkg::WORD_W-1:0]         owner_word2,
  input  logic [gttl_pkg::WORD_W-1:0]         owner_word3,
  input  logic [gttl_pkg::TIME_BITS-1:0]      now_tick,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                hit,
  output logic [gttl_pkg::CNT_W-1:0]          removed,
  output logic [gttl_pkg::CNT_W-1:0]          occupancy,
  output logic                                dropped_full
);

  // captured transaction
  logic [gttl_pkg::MODE_W-1:0]    mode_q;
  logic [gttl_pkg::KEY_W-1:0]     key_q;
  logic [gttl_pkg::KEY_W-1:0]     owner_q;
  logic [gttl_pkg::TIME_BITS-1:0] now_q;
  logic [gttl_pkg::TIME_BITS-1:0] cutoff;
  logic                           evict_ok;
  logic [gttl_pkg::TTL_W-1:0]     gap_ttl;

  // memories and read registers
  logic [gttl_pkg::KEY_W-1:0]     key_mem   [gttl_pkg::ENTRIES];
  logic [gttl_pkg::KEY_W-1:0]     owner_mem [gttl_pkg::ENTRIES];
  logic [gttl_pkg::TIME_BITS-1:0] stamp_mem [gttl_pkg::ENTRIES];
  logic [gttl_pkg::KEY_W-1:0]     key_rd;
  logic [gttl_pkg::KEY_W-1:0]     owner_rd;
  logic [gttl_pkg::TIME_BITS-1:0] stamp_rd;

  // scan and table state
  logic [gttl_pkg::CNT_W-1:0]     scan_idx;
  logic [gttl_pkg::IDX_W-1:0]     rd_addr;
  logic [gttl_pkg::IDX_W-1:0]     cmp_idx;
  logic                           cmp_valid;
  logic [gttl_pkg::ENTRIES-1:0]   entry_valid;
  logic [gttl_pkg::CNT_W-1:0]     valid_count;

  // per-transaction results
  logic                           hit_q;
  logic                           dropped_q;
  logic [gttl_pkg::CNT_W-1:0]     removed_q;
  logic                           free_found;
  logic [gttl_pkg::IDX_W-1:0]     free_idx;
  logic [gttl_pkg::IDX_W-1:0]     match_idx;

  logic op_track, op_resolve, op_rollback, op_evict, op_clear, op_scan;
  logic issue, cur_valid, key_eq, owner_eq, stale;
  logic erase, track_hit, free_seen;
  logic trk_new, trk_refresh, trk_drop, do_clear;
  logic kv_we, stamp_we;
  logic [gttl_pkg::IDX_W-1:0] wr_idx;

  // operation decode
  assign op_track    = (mode_q == gttl_pkg::MODE_TRACK);
  assign op_resolve  = (mode_q == gttl_pkg::MODE_RESOLVE);
  assign op_rollback = (mode_q == gttl_pkg::MODE_ROLLBACK);
  assign op_evict    = (mode_q == gttl_pkg::MODE_EVICT);
  assign op_clear    = (mode_q == gttl_pkg::MODE_CLEAR);
  assign op_scan     = op_track | op_resolve | op_rollback | op_evict;

  // ttl register
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ttl <= '0;
    end else if (cfg_we) begin
      gap_ttl <= cfg_data;
    end
  end

  // capture transaction and precompute eviction cutoff
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode;
      key_q    <= {key_word3, key_word2, key_word1, key_word0};
      owner_q  <= {owner_word3, owner_word2, owner_word1, owner_word0};
      now_q    <= now_tick;
      cutoff   <= now_tick - gap_ttl;
      evict_ok <= (now_tick >= gap_ttl);
    end
  end

  // scan address counter, one entry per cycle
  assign rd_addr = scan_idx[gttl_pkg::IDX_W-1:0];
  assign issue   = cmd.scan && op_scan && (scan_idx != gttl_pkg::ENTRIES_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
      end else if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      cmp_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_addr;
  end

  assign sts.scan_done = !op_scan || (scan_idx == gttl_pkg::ENTRIES_CNT);
  assign sts.out_free  = !out_valid || !out_stall;

  // memories: one write at commit, one registered read per scan cycle
  assign wr_idx   = hit_q ? match_idx : free_idx;
  assign kv_we    = trk_new;
  assign stamp_we = trk_new | trk_refresh;

  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[wr_idx]   <= key_q;
      owner_mem[wr_idx] <= owner_q;
    end
    if (issue) begin
      key_rd   <= key_mem[rd_addr];
      owner_rd <= owner_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[wr_idx] <= now_q;
    end
    if (issue) begin
      stamp_rd <= stamp_mem[rd_addr];
    end
  end

  // compare stage
  assign cur_valid = entry_valid[cmp_idx];
  assign key_eq    = (key_rd == key_q);
  assign owner_eq  = (owner_rd == owner_q);
  assign stale     = (stamp_rd < cutoff);

  assign erase = cmp_valid && cur_valid &&
                 ((op_resolve && key_eq) || (op_rollback && owner_eq) ||
                  (op_evict && evict_ok && stale));
  assign track_hit = cmp_valid && cur_valid && op_track && key_eq;
  assign free_seen = cmp_valid && !cur_valid && op_track && !free_found;

  // commit actions
  assign trk_new     = cmd.commit && op_track && !hit_q && free_found;
  assign trk_refresh = cmd.commit && op_track && hit_q;
  assign trk_drop    = cmd.commit && op_track && !hit_q && !free_found;
  assign do_clear    = cmd.commit && op_clear;

  // valid bits and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      valid_count <= '0;
    end else if (do_clear) begin
      entry_valid <= '0;
      valid_count <= '0;
    end else begin
      if (erase) begin
        entry_valid[cmp_idx] <= 1'b0;
        valid_count          <= valid_count - 1'b1;
      end
      if (trk_new) begin
        entry_valid[free_idx] <= 1'b1;
        valid_count           <= valid_count + 1'b1;
      end
    end
  end

  // per-transaction flags and counts
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_q      <= 1'b0;
      dropped_q  <= 1'b0;
      removed_q  <= '0;
      free_found <= 1'b0;
    end else begin
      if (track_hit || (erase && op_resolve)) begin
        hit_q <= 1'b1;
      end
      if (track_hit) begin
        match_idx <= cmp_idx;
      end
      if (free_seen) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
      if (erase) begin
        removed_q <= removed_q + 1'b1;
      end
      if (do_clear) begin
        removed_q <= valid_count;
      end
      if (trk_drop) begin
        dropped_q <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hit          <= hit_q;
      removed      <= removed_q;
      occupancy    <= valid_count;
      dropped_full <= dropped_q;
    end
  end

endmodule

[hw/rtl/gap_tracking_table_with_ttl.sv]
// top level of the gap tracking table with time-to-live
//
// Input channel (in_valid / in_stall) carries one operation per transaction:
// mode, a 256-bit key, a 256-bit owner and now_tick. Output channel
// (out_valid / out_stall) returns one result per transaction: hit, removed,
// occupancy and dropped_full. gap_ttl is written through cfg_we / cfg_data.
// Track, resolve, rollback and evict walk all 64 entries through the key,
// owner and stamp memories, one entry per cycle with a registered read, then
// pass through the commit and emit states before the result register loads;
// clear and unused modes skip the walk. The single memory read port sets the
// length of the walk.
// One transaction is in flight at a time: in_stall is high from accept until
// the result is loaded into the output register. A new transaction may be
// accepted while that result still waits on out_stall; it then holds in its
// final state until the output register frees up.
// Reset empties the table, clears gap_ttl and drops any pending result.
module gap_tracking_table_with_ttl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gttl_pkg::TTL_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [gttl_pkg::MODE_W-1:0]       mode,
  input  logic [gttl_pkg::WORD_W-1:0]       key_word0,
  input  logic [gttl_pkg::WORD_W-1:0]       key_word1,
  input  logic [gttl_pkg::WORD_W-1:0]       key_word2,
  input  logic [gttl_pkg::WORD_W-1:0]       key_word3,
  input  logic [gttl_pkg::WORD_W-1:0]       owner_word0,
  input  logic [gttl_pkg::WORD_W-1:0]       owner_word1,
  input  logic [gttl_pkg::WORD_W-1:0]       owner_word2,
  input  logic [gttl_pkg::WORD_W-1:0]       owner_word3,
  input  logic [gttl_pkg::TIME_BITS-1:0]    now_tick,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic [gttl_pkg::CNT_W-1:0]        removed,
  output logic [gttl_pkg::CNT_W-1:0]        occupancy,
  output logic                              dropped_full
);

  gttl_pkg::ctrl_cmd_t  cmd;
  gttl_pkg::dp_status_t sts;

  // sequencing
  gttl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table storage and compare
  gttl_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .key_word0    (key_word0),
    .key_word1    (key_word1),
    .key_word2    (key_word2),
    .key_word3    (key_word3),
    .owner_word0  (owner_word0),
    .owner_word1  (owner_word1),
    .owner_word2  (owner_word2),
    .owner_word3  (owner_word3),
    .now_tick     (now_tick),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .hit          (hit),
    .removed      (removed),
    .occupancy    (occupancy),
    .dropped_full (dropped_full)
  );

endmodule

[hw/rtl/gttl_checker.sv]
// port-level checker for the gap tracking table, bound to the top level
`include "gap_tracking_table_with_ttl_assert.svh"

module gttl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          hit,
  input logic [gttl_pkg::CNT_W-1:0]    removed,
  input logic [gttl_pkg::CNT_W-1:0]    occupancy,
  input logic                          dropped_full
);

  logic drop_seen;
  logic drop_ok;
  logic out_held;

  assign drop_seen = out_valid && dropped_full;
  assign drop_ok   = (occupancy == gttl_pkg::ENTRIES_CNT) && (removed == '0) && !hit;
  assign out_held  = out_valid && out_stall;

  // occupancy never exceeds the table size
  `GTTL_ASSERT_NOW(a_occ_bound, out_valid, occupancy <= gttl_pkg::ENTRIES_CNT, "occupancy too big")

  // a dropped track only happens on a full table and erases nothing
  `GTTL_ASSERT_NOW(a_drop_full, drop_seen, drop_ok, "drop on non-full table")

  // a hit erases at most one entry since keys are unique
  `GTTL_ASSERT_NOW(a_hit_removed, out_valid && hit, removed <= 7'd1, "hit removed more than one")

  // only one transaction in flight: stall rises right after an accept
  `GTTL_ASSERT_NEXT(a_one_inflight, in_valid && !in_stall, in_stall, "accepted while busy")

  // a stalled result holds
  `GTTL_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(occupancy), "result moved")

endmodule

bind gap_tracking_table_with_ttl gttl_checker u_gttl_checker (.*);

[dv/gap_tracking_table_with_ttl_tb.sv]
// testbench for the gap tracking table with time-to-live
`timescale 1ns / 1ps

module gap_tracking_table_with_ttl_tb;

  localparam int ENTRIES   = gttl_pkg::ENTRIES;
  localparam int CNT_W     = gttl_pkg::CNT_W;
  localparam int KEY_W     = gttl_pkg::KEY_W;
  localparam int WORD_W    = gttl_pkg::WORD_W;
  localparam int TIME_BITS = gttl_pkg::TIME_BITS;
  localparam int TTL_W     = gttl_pkg::TTL_W;
  localparam int MODE_W    = gttl_pkg::MODE_W;

  localparam int CYCLE_LIMIT = 600_000;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam int KEY_POOL_SIZE = 80;
  localparam int OWNER_POOL_SIZE = 6;

  typedef struct {
    logic [MODE_W-1:0]    mode;
    logic [KEY_W-1:0]     key;
    logic [KEY_W-1:0]     owner;
    logic [TIME_BITS-1:0] now;
  } gap_op_t;

  typedef struct {
    logic             hit;
    logic [CNT_W-1:0] removed;
    logic [CNT_W-1:0] occupancy;
    logic             dropped;
  } gap_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [TTL_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [MODE_W-1:0]    mode = '0;
  logic [WORD_W-1:0]    key_word0 = '0;
  logic [WORD_W-1:0]    key_word1 = '0;
  logic [WORD_W-1:0]    key_word2 = '0;
  logic [WORD_W-1:0]    key_word3 = '0;
  logic [WORD_W-1:0]    owner_word0 = '0;
  logic [WORD_W-1:0]    owner_word1 = '0;
  logic [WORD_W-1:0]    owner_word2 = '0;
  logic [WORD_W-1:0]    owner_word3 = '0;
  logic [TIME_BITS-1:0] now_tick = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 hit;
  logic [CNT_W-1:0]     removed;
  logic [CNT_W-1:0]     occupancy;
  logic                 dropped_full;

  // predicted table contents
  bit                   slot_live [ENTRIES];
  logic [KEY_W-1:0]     slot_key [ENTRIES];
  logic [KEY_W-1:0]     slot_owner [ENTRIES];
  logic [TIME_BITS-1:0] slot_stamp [ENTRIES];
  int                   live_count = 0;
  logic [TTL_W-1:0]     ttl_model = '0;

  gap_result_t          pending_results[$];
  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  int                   hold_left = 0;
  bit                   calm = 1'b0;
  logic [KEY_W-1:0]     key_pool [KEY_POOL_SIZE];
  logic [KEY_W-1:0]     owner_pool [OWNER_POOL_SIZE];
  logic [TIME_BITS-1:0] now_base = '0;

  gap_tracking_table_with_ttl uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .key_word0    (key_word0),
    .key_word1    (key_word1),
    .key_word2    (key_word2),
    .key_word3    (key_word3),
    .owner_word0  (owner_word0),
    .owner_word1  (owner_word1),
    .owner_word2  (owner_word2),
    .owner_word3  (owner_word3),
    .now_tick     (now_tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .removed      (removed),
    .occupancy    (occupancy),
    .dropped_full (dropped_full)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side stall: long hold-off, quiet stretch or random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else if (calm) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(0, 99) < 17);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    mismatch_count++;
  endtask

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_result
    gap_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) report_mismatch("hit", 64'(want.hit), 64'(hit));
        if (removed !== want.removed)
          report_mismatch("removed", 64'(want.removed), 64'(removed));
        if (occupancy !== want.occupancy)
          report_mismatch("occupancy", 64'(want.occupancy), 64'(occupancy));
        if (dropped_full !== want.dropped)
          report_mismatch("dropped_full", 64'(want.dropped), 64'(dropped_full));
      end
    end
  end

  // apply one operation to the predicted table and return its result
  function automatic gap_result_t predict_table_op(input gap_op_t op);
    gap_result_t          r;
    int                   free_slot;
    logic [TIME_BITS-1:0] cutoff;
    r = '{hit: 1'b0, removed: '0, occupancy: '0, dropped: 1'b0};
    free_slot = -1;
    case (op.mode)
      gttl_pkg::MODE_TRACK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_live[i] && slot_key[i] == op.key) begin
            slot_stamp[i] = op.now;
            r.hit = 1'b1;
            break;
          end
          if (!slot_live[i] && free_slot < 0) free_slot = i;
        end
        if (!r.hit) begin
          if (free_slot < 0) begin
            r.dropped = 1'b1;
          end else begin
            slot_live[free_slot]  = 1'b1;
            slot_key[free_slot]   = op.key;
            slot_owner[free_slot] = op.owner;
            slot_stamp[free_slot] = op.now;
            live_count++;
          end
        end
      end
      gttl_pkg::MODE_RESOLVE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_live[i] && slot_key[i] == op.key) begin
            slot_live[i] = 1'b0;
            live_count--;
            r.hit = 1'b1;
            r.removed = CNT_W'(1);
            break;
          end
        end
      end
      gttl_pkg::MODE_ROLLBACK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_live[i] && slot_owner[i] == op.owner) begin
            slot_live[i] = 1'b0;
            live_count--;
            r.removed++;
          end
        end
      end
      gttl_pkg::MODE_EVICT: begin
        // nothing ages out before the ttl has elapsed
        if (op.now >= ttl_model) begin
          cutoff = op.now - ttl_model;
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && slot_stamp[i] < cutoff) begin
              slot_live[i] = 1'b0;
              live_count--;
              r.removed++;
            end
          end
        end
      end
      gttl_pkg::MODE_CLEAR: begin
        r.removed = CNT_W'(live_count);
        for (int i = 0; i < ENTRIES; i++) slot_live[i] = 1'b0;
        live_count = 0;
      end
      default: ;
    endcase
    r.occupancy = CNT_W'(live_count);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_wide();
    logic [KEY_W-1:0] v;
    for (int w = 0; w < KEY_W / 32; w++) v[32*w +: 32] = $urandom;
    return v;
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  function automatic gap_op_t make_op(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                                      input logic [KEY_W-1:0] o,
                                      input logic [TIME_BITS-1:0] t);
    gap_op_t op;
    op.mode  = m;
    op.key   = k;
    op.owner = o;
    op.now   = t;
    return op;
  endfunction

  // one input transaction: optional idle cycles, then hold until accepted
  task automatic send_op(input gap_op_t op);
    if (!calm) begin
      while ($urandom_range(0, 99) < 17) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    mode        = op.mode;
    key_word0   = op.key[63:0];
    key_word1   = op.key[127:64];
    key_word2   = op.key[191:128];
    key_word3   = op.key[255:192];
    owner_word0 = op.owner[63:0];
    owner_word1 = op.owner[127:64];
    owner_word2 = op.owner[191:128];
    owner_word3 = op.owner[255:192];
    now_tick    = op.now;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_table_op(op));
  endtask

  // write the ttl once every pending result has drained
  task automatic write_ttl(input logic [TTL_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    ttl_model = value;
  endtask

  // random operation drawn mostly from small key and owner pools
  function automatic gap_op_t random_op();
    gap_op_t op;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 50) op.mode = gttl_pkg::MODE_TRACK;
    else if (r < 70) op.mode = gttl_pkg::MODE_RESOLVE;
    else if (r < 78) op.mode = gttl_pkg::MODE_ROLLBACK;
    else if (r < 92) op.mode = gttl_pkg::MODE_EVICT;
    else if (r < 93) op.mode = gttl_pkg::MODE_CLEAR;
    else op.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    op.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]
                                          : rand_wide();
    op.owner = ($urandom_range(0, 99) < 80) ?
               owner_pool[$urandom_range(0, OWNER_POOL_SIZE - 1)] : rand_wide();
    now_base = now_base + TIME_BITS'($urandom_range(0, 40));
    r = $urandom_range(0, 99);
    if (r < 5) op.now = rand_time();
    else if (r < 7) op.now = TIME_MAX;
    else op.now = now_base;
    return op;
  endfunction

  // every operation with field extremes and the special cases
  task automatic test_directed_ops();
    logic [KEY_W-1:0] ka, kb, oa, ob;
    ka = rand_wide();
    kb = rand_wide();
    oa = rand_wide();
    ob = rand_wide();
    send_op(make_op(gttl_pkg::MODE_TRACK, '1, oa, TIME_BITS'(100)));
    send_op(make_op(gttl_pkg::MODE_TRACK, '0, '1, TIME_MAX));
    // refresh of a present key keeps its first owner
    send_op(make_op(gttl_pkg::MODE_TRACK, '1, ob, TIME_BITS'(200)));
    send_op(make_op(gttl_pkg::MODE_TRACK, ka, oa, TIME_BITS'(150)));
    send_op(make_op(gttl_pkg::MODE_RESOLVE, '0, '0, '0));
    // resolve of an absent key
    send_op(make_op(gttl_pkg::MODE_RESOLVE, '0, '1, '0));
    send_op(make_op(gttl_pkg::MODE_ROLLBACK, kb, ob, '0));
    send_op(make_op(gttl_pkg::MODE_ROLLBACK, '0, oa, '0));
    send_op(make_op(gttl_pkg::MODE_TRACK, '0, '1, '0));
    send_op(make_op(gttl_pkg::MODE_TRACK, ka, '0, TIME_BITS'(50)));
    send_op(make_op(gttl_pkg::MODE_TRACK, kb, ob, TIME_BITS'(500)));
    // ttl of zero ages out anything stamped below now
    send_op(make_op(gttl_pkg::MODE_EVICT, '1, '1, TIME_BITS'(300)));
    write_ttl(TTL_W'(1000));
    // evict before the ttl has elapsed
    send_op(make_op(gttl_pkg::MODE_EVICT, '0, '0, TIME_BITS'(10)));
    send_op(make_op(gttl_pkg::MODE_EVICT, '0, '0, TIME_MAX));
    send_op(make_op(gttl_pkg::MODE_TRACK, ka, oa, TIME_BITS'(7)));
    send_op(make_op(gttl_pkg::MODE_CLEAR, '1, '1, TIME_MAX));
    for (int m = int'(MODE_SPARE_LO); m <= int'(MODE_SPARE_HI); m++)
      send_op(make_op(MODE_W'(m), rand_wide(), rand_wide(), rand_time()));
    write_ttl(TIME_MAX);
    send_op(make_op(gttl_pkg::MODE_TRACK, ka, oa, '0));
    send_op(make_op(gttl_pkg::MODE_EVICT, '0, '0, TIME_MAX));
    send_op(make_op(gttl_pkg::MODE_CLEAR, '0, '0, '0));
  endtask

  // fill the table, starting while results are held off, then overflow it
  task automatic test_full_table_backpressure();
    logic [KEY_W-1:0] fill_keys [ENTRIES];
    logic [KEY_W-1:0] shared_owner;
    shared_owner = rand_wide();
    for (int i = 0; i < ENTRIES; i++) begin
      fill_keys[i] = rand_wide();
      fill_keys[i][31:0] = 32'h8000_0000 | i;
    end
    write_ttl('0);
    hold_left = 400;
    for (int i = 0; i < ENTRIES; i++)
      send_op(make_op(gttl_pkg::MODE_TRACK, fill_keys[i],
                      (i % 3 == 0) ? shared_owner : rand_wide(), TIME_BITS'(i)));
    // new keys into a full table are dropped, a present key still hits
    send_op(make_op(gttl_pkg::MODE_TRACK, rand_wide(), shared_owner, TIME_BITS'(90)));
    send_op(make_op(gttl_pkg::MODE_TRACK, '1, '1, TIME_BITS'(91)));
    send_op(make_op(gttl_pkg::MODE_TRACK, fill_keys[ENTRIES - 1], '0, TIME_BITS'(92)));
    send_op(make_op(gttl_pkg::MODE_RESOLVE, fill_keys[5], '0, '0));
    send_op(make_op(gttl_pkg::MODE_TRACK, rand_wide(), shared_owner, TIME_BITS'(93)));
    send_op(make_op(gttl_pkg::MODE_ROLLBACK, '0, shared_owner, '0));
    send_op(make_op(gttl_pkg::MODE_EVICT, '0, '0, TIME_BITS'(40)));
    send_op(make_op(gttl_pkg::MODE_CLEAR, '0, '0, '0));
  endtask

  task automatic run_random_phase(input logic [TTL_W-1:0] ttl, input int count,
                                  input bit quiet);
    write_ttl(ttl);
    calm = quiet;
    repeat (count) send_op(random_op());
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = rand_wide();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 0; i < OWNER_POOL_SIZE; i++) owner_pool[i] = rand_wide();
    owner_pool[0] = '1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_ops();
    test_full_table_backpressure();
    run_random_phase('0, 220, 1'b0);
    run_random_phase(TTL_W'(200), 220, 1'b0);
    run_random_phase(TIME_MAX, 150, 1'b0);
    run_random_phase(TTL_W'(1), 220, 1'b1);
    run_random_phase(TTL_W'($urandom_range(20, 5000)), 220, 1'b0);
    run_random_phase(TTL_W'(40), 100, 1'b0);

    // drain and let the block settle
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/gttl_pkg.sv
hw/rtl/gttl_ctrl.sv
hw/rtl/gttl_datapath.sv
hw/rtl/gap_tracking_table_with_ttl.sv
hw/rtl/gttl_checker.sv
dv/gap_tracking_table_with_ttl_tb.sv
